### rtl/malu_pkg.sv
// Package for the ALU with clip and divide step: operation codes, widths,
// and the struct passed from the execute logic to the top level.
// No dependencies.
package malu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int OP_WIDTH   = 5;
    localparam int STEP_WIDTH = 5;
    localparam int LUI_SHIFT  = 16;
    localparam int CLIP_MAX   = 255;

    typedef enum logic [OP_WIDTH-1:0] {
        OP_AND     = 5'h00,
        OP_OR      = 5'h01,
        OP_ADD     = 5'h02,
        OP_ADDU    = 5'h03,
        OP_XOR     = 5'h04,
        OP_SUB     = 5'h06,
        OP_SLT     = 5'h07,
        OP_SLTU    = 5'h08,
        OP_LUI     = 5'h09,
        OP_SLL1    = 5'h0A,
        OP_SLL2    = 5'h0B,
        OP_SLL8    = 5'h0C,
        OP_SRL1    = 5'h0D,
        OP_SRL2    = 5'h0E,
        OP_SRL8    = 5'h0F,
        OP_SRA1    = 5'h10,
        OP_SRA2    = 5'h11,
        OP_SRA8    = 5'h12,
        OP_MULTU   = 5'h13,
        OP_CLIP    = 5'h14,
        OP_DIVSTEP = 5'h15,
        OP_MULT2   = 5'h16
    } t_op;

    typedef struct packed {
        logic [OP_WIDTH-1:0]   action;
        logic [DATA_WIDTH-1:0] operand_a;
        logic [DATA_WIDTH-1:0] operand_b;
        logic [STEP_WIDTH-1:0] divide_step;
        logic [DATA_WIDTH-1:0] partial_quotient;
    } t_req;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] result;
        logic [DATA_WIDTH-1:0] hi;
        logic                  hi_we;
        logic                  zero;
        logic                  zero_we;
        logic [STEP_WIDTH-1:0] step;
        logic                  step_we;
        logic                  done;
    } t_exec;

endpackage

### rtl/malu_exec.sv
// Execute logic of the ALU: logic ops, add/sub, compares, fixed shifts,
// one shared 33x33 signed multiplier for multiply and divide step, clip.
// Depends on malu_pkg.
module malu_exec (
    input  malu_pkg::t_req  i_req,
    output malu_pkg::t_exec o_exec
);
    import malu_pkg::*;

    logic [DATA_WIDTH-1:0]   a;
    logic [DATA_WIDTH-1:0]   b;
    logic [DATA_WIDTH-1:0]   sum;
    logic [DATA_WIDTH-1:0]   diff;
    logic [DATA_WIDTH-1:0]   q_base;
    logic [DATA_WIDTH-1:0]   q_bit;
    logic [DATA_WIDTH-1:0]   q_try;
    logic [DATA_WIDTH-1:0]   q_keep;
    logic                    is_div;
    logic signed [DATA_WIDTH:0]     mul_x;
    logic signed [DATA_WIDTH:0]     mul_y;
    logic signed [2*DATA_WIDTH+1:0] prod;
    logic signed [2*DATA_WIDTH+1:0] a_ext;
    t_op                     op;

    assign op   = t_op'(i_req.action);
    assign a    = i_req.operand_a;
    assign b    = i_req.operand_b;
    assign sum  = a + b;
    assign diff = a - b;

    // Divide step: try bit 31-step, drop it if b*q exceeds a
    assign is_div = (op == OP_DIVSTEP);
    assign q_base = (i_req.divide_step == '0) ? '0 : i_req.partial_quotient;
    assign q_bit  = {1'b1, {(DATA_WIDTH-1){1'b0}}} >> i_req.divide_step;
    assign q_try  = q_base | q_bit;

    // Shared multiplier: unsigned a*b, or signed b times unsigned q
    assign mul_x  = is_div ? $signed({1'b0, q_try}) : $signed({1'b0, a});
    assign mul_y  = $signed({is_div & b[DATA_WIDTH-1], b});
    assign prod   = mul_x * mul_y;
    assign a_ext  = $signed({{(DATA_WIDTH+2){a[DATA_WIDTH-1]}}, a});
    assign q_keep = (prod > a_ext) ? (q_try & ~q_bit) : q_try;

    always_comb begin
        o_exec         = '0;
        o_exec.done    = 1'b1;
        case (op)
            OP_AND:  o_exec.result = a & b;
            OP_OR:   o_exec.result = a | b;
            OP_XOR:  o_exec.result = a ^ b;
            OP_ADD, OP_ADDU: begin
                o_exec.result  = sum;
                o_exec.zero_we = 1'b1;
            end
            OP_SUB: begin
                o_exec.result  = diff;
                o_exec.zero_we = 1'b1;
            end
            OP_SLT: begin
                o_exec.result  = {{(DATA_WIDTH-1){1'b0}}, ($signed(a) < $signed(b))};
                o_exec.zero_we = 1'b1;
            end
            OP_SLTU: begin
                o_exec.result  = {{(DATA_WIDTH-1){1'b0}}, (a < b)};
                o_exec.zero_we = 1'b1;
            end
            OP_LUI:  o_exec.result = b << LUI_SHIFT;
            OP_SLL1: o_exec.result = b << 1;
            OP_SLL2: o_exec.result = b << 2;
            OP_SLL8: o_exec.result = b << 8;
            OP_SRL1: o_exec.result = b >> 1;
            OP_SRL2: o_exec.result = b >> 2;
            OP_SRL8: o_exec.result = b >> 8;
            OP_SRA1: o_exec.result = $unsigned($signed(b) >>> 1);
            OP_SRA2: o_exec.result = $unsigned($signed(b) >>> 2);
            OP_SRA8: o_exec.result = $unsigned($signed(b) >>> 8);
            OP_MULTU, OP_MULT2: begin
                o_exec.result = prod[DATA_WIDTH-1:0];
                o_exec.hi     = prod[2*DATA_WIDTH-1:DATA_WIDTH];
                o_exec.hi_we  = 1'b1;
            end
            OP_CLIP: begin
                if (b[DATA_WIDTH-1]) begin
                    o_exec.result = '0;
                end else if (|b[DATA_WIDTH-2:8]) begin
                    o_exec.result = DATA_WIDTH'(CLIP_MAX);
                end else begin
                    o_exec.result = b;
                end
            end
            OP_DIVSTEP: begin
                o_exec.result  = (|q_keep[DATA_WIDTH-1:8]) ? DATA_WIDTH'(CLIP_MAX) : q_keep;
                o_exec.step_we = 1'b1;
                // Last step wraps to zero and reports done
                o_exec.step    = i_req.divide_step + 1'b1;
                o_exec.done    = (i_req.divide_step == '1);
            end
            default: o_exec.result = '0;
        endcase
        o_exec.zero = (o_exec.result == '0);
    end

endmodule

### rtl/mips_alu_with_clip_divide_core.sv
// Top level of the ALU with clip and divide step: input register, execute
// logic, result register and the held zero / high-word / next-step registers.
// Depends on malu_pkg and malu_exec.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+----------------------------------------
//   request | in        | i_valid / o_ready  | action, operand_a/b, step, quotient
//   result  | out       | o_valid / i_ready  | result, high_word, zero, step, done
//
// One request per cycle while the result is not stalled; a taken request goes
// into the input register and then on into the result register, which offers
// the result to the result channel. The single path through the shared
// 33x33 multiplier sets the cycle. Synchronous active-low reset clears valids
// and the held zero flag, high word and next step. A stalled result holds both
// stages; the request side keeps taking requests while the input stage is free.
module mips_alu_with_clip_divide_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [malu_pkg::OP_WIDTH-1:0]       i_action,
    input  logic [malu_pkg::DATA_WIDTH-1:0]     i_operand_a,
    input  logic [malu_pkg::DATA_WIDTH-1:0]     i_operand_b,
    input  logic [malu_pkg::STEP_WIDTH-1:0]     i_divide_step,
    input  logic [malu_pkg::DATA_WIDTH-1:0]     i_partial_quotient,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [malu_pkg::DATA_WIDTH-1:0]     o_result,
    output logic [malu_pkg::DATA_WIDTH-1:0]     o_high_word,
    output logic                                o_zero_flag,
    output logic [malu_pkg::STEP_WIDTH-1:0]     o_next_step,
    output logic                                o_done_res
);
    import malu_pkg::*;

    logic                  r_s1_valid;
    t_req                  r_s1_req;
    logic                  r_out_valid;
    logic [DATA_WIDTH-1:0] r_out_result;
    logic                  r_out_done;
    logic                  r_held_zero;
    logic [DATA_WIDTH-1:0] r_held_hi;
    logic [STEP_WIDTH-1:0] r_held_step;
    logic                  s1_adv;
    logic                  s1_fire;
    logic                  in_fire;
    t_exec                 exec;

    assign s1_adv  = !r_out_valid || i_ready;
    assign s1_fire = r_s1_valid && s1_adv;
    assign o_ready = !r_s1_valid || s1_adv;
    assign in_fire = i_valid && o_ready;

    malu_exec u_exec (
        .i_req  (r_s1_req),
        .o_exec (exec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_held_zero <= 1'b0;
            r_held_hi   <= '0;
            r_held_step <= '0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
            // Held registers move only with the request that writes them
            if (s1_fire) begin
                if (exec.zero_we) begin
                    r_held_zero <= exec.zero;
                end
                if (exec.hi_we) begin
                    r_held_hi <= exec.hi;
                end
                if (exec.step_we) begin
                    r_held_step <= exec.step;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_req.action           <= i_action;
            r_s1_req.operand_a        <= i_operand_a;
            r_s1_req.operand_b        <= i_operand_b;
            r_s1_req.divide_step      <= i_divide_step;
            r_s1_req.partial_quotient <= i_partial_quotient;
        end
        if (s1_fire) begin
            r_out_result <= exec.result;
            r_out_done   <= exec.done;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_result    = r_out_result;
    assign o_done_res  = r_out_done;
    assign o_high_word = r_held_hi;
    assign o_zero_flag = r_held_zero;
    assign o_next_step = r_held_step;

`ifndef SYNTHESIS
    a_step_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_done_res) |-> (o_next_step != '0))
        else $error("divide step pending but next step is zero");

    a_div_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_done_res) |-> (o_result[DATA_WIDTH-1:8] == '0))
        else $error("divide step result not saturated");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_s1_req)))
        else $error("input stage lost its request during a stall");
`endif

endmodule
